@@ rtl/core/rtd_pkg.sv @@
// ---------------------------------------------------------------------------
// rtd_pkg: shared types and helpers for the record serial-type decoder
// Holds the phase and class codes, the queued input word, the result kinds
// and the serial-type classification used by the decoding engine.
// ---------------------------------------------------------------------------
package rtd_pkg;

    // Number of columns kept per record (column_index is 5 bits wide).
    localparam int unsigned CAPACITY    = 32;
    localparam int unsigned COL_W       = $clog2(CAPACITY);
    localparam int unsigned COUNT_W     = COL_W + 1;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HSIZE,
        PH_TYPES,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        CL_NULL,
        CL_INT,
        CL_FLOAT,
        CL_CONST0,
        CL_CONST1,
        CL_BLOB,
        CL_TEXT
    } cls_t;

    // Result kinds as they appear on the output.
    localparam logic [2:0] KIND_NULL  = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_FLOAT = 3'd2;
    localparam logic [2:0] KIND_BLOB  = 3'd3;
    localparam logic [2:0] KIND_TEXT  = 3'd4;
    localparam logic [2:0] KIND_EMPTY = 3'd5;

    typedef struct packed {
        logic [15:0] length;
        logic        start;
        logic [7:0]  data;
    } in_word_t;

    typedef struct packed {
        cls_t        cls;
        logic [15:0] len;
        logic        big;   // length does not fit in 16 bits
    } cls_info_t;

    typedef struct packed {
        logic [63:0] accum;
        logic [3:0]  count;
        logic        done;
    } vint_t;

    typedef struct packed {
        logic [QPTR_W:0] count;
    } front_status_t;

    typedef struct packed {
        phase_t phase;
        logic   scan;
    } engine_status_t;

    // Serial type to column class and body length.
    function automatic cls_info_t classify(input logic [63:0] t);
        cls_info_t   r;
        logic [62:0] l;
        begin
            r.cls = CL_NULL;
            r.len = '0;
            r.big = 1'b0;
            // For both blob and text the length is (t >> 1) - 6.
            l = t[63:1] - 63'd6;
            priority if (t[63])
            begin
                r.cls = CL_NULL;
            end
            else if (t >= 64'd1 && t <= 64'd6)
            begin
                r.cls = CL_INT;
                unique case (t[2:0])
                    3'd1:    r.len = 16'd1;
                    3'd2:    r.len = 16'd2;
                    3'd3:    r.len = 16'd3;
                    3'd4:    r.len = 16'd4;
                    3'd5:    r.len = 16'd6;
                    default: r.len = 16'd8;
                endcase
            end
            else if (t == 64'd7)
            begin
                r.cls = CL_FLOAT;
                r.len = 16'd8;
            end
            else if (t == 64'd8)
            begin
                r.cls = CL_CONST0;
            end
            else if (t == 64'd9)
            begin
                r.cls = CL_CONST1;
            end
            else if (t >= 64'd12)
            begin
                r.cls = t[0] ? CL_TEXT : CL_BLOB;
                r.len = l[15:0];
                r.big = |l[62:16];
            end
            else
            begin
                r.cls = CL_NULL;
            end
            return r;
        end
    endfunction

    // One byte into a varint: seven bits for the first eight bytes, then eight.
    function automatic vint_t vint_push(input logic [63:0] accum, input logic [3:0] count,
                                        input logic [7:0] b);
        vint_t r;
        begin
            if (count < 4'd8)
            begin
                r.accum = {accum[56:0], b[6:0]};
                r.done  = ~b[7];
            end
            else
            begin
                r.accum = {accum[55:0], b};
                r.done  = 1'b1;
            end
            r.count = count + 4'd1;
            return r;
        end
    endfunction

endpackage

@@ rtl/core/record_serial_type_decoder_core.sv @@
// ---------------------------------------------------------------------------
// record_serial_type_decoder_core: streaming record format decoder
// Decodes a record payload, one byte per word, into per-column results.
// ---------------------------------------------------------------------------
// Each input word carries one payload byte. The word flagged as a record start
// also carries the payload length. The header-size and serial-type varints are
// decoded into a 32-entry column table, taking one header byte per cycle while
// a word is queued and the output is not stalled. The body is then decoded
// column by column. Opening a column is a scan step in which no word is
// taken. A column that needs body bytes then takes one byte per cycle under
// the same conditions and gives at most one result per byte. A column that
// needs none (null, the constants 0 and 1, empty text, a blob marker, or a
// column past the end of the record) is finished in its opening step. A
// last scan step closes the body after its last column, and a run of
// columns that need no body bytes stalls the input while they are opened.
// A four-word queue sits in front of the engine. The engine stops whenever a
// result waits on the output, and the single result register lets a new
// result be formed in the same cycle that the previous one is taken.
// ---------------------------------------------------------------------------
module record_serial_type_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] record_length
    input  logic        s_tuser,   // [0] record_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [4:0] column_index, [68:5] value, rest zero
    output logic [4:0]  m_tuser,   // [2:0] kind, [3] column_done, [4] truncated
    output logic        m_tlast    // record_done
);

    rtd_pkg::in_word_t       in_word;
    rtd_pkg::in_word_t       q_word;
    logic                    q_valid;
    logic                    q_pop;
    rtd_pkg::front_status_t  front_status;
    rtd_pkg::engine_status_t engine_status;

    logic [4:0]  out_column;
    logic [2:0]  out_kind;
    logic [63:0] out_value;
    logic        out_cdone;
    logic        out_rdone;
    logic        out_trunc;

    assign in_word.data   = s_tdata[7:0];
    assign in_word.length = s_tdata[23:8];
    assign in_word.start  = s_tuser;

    // Front end: absorbs the incoming stream while the engine is busy.
    rtd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_word  (in_word),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .status   (front_status)
    );

    // Back end: header parsing, column table and body decoding.
    rtd_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_column (out_column),
        .out_kind   (out_kind),
        .out_value  (out_value),
        .out_cdone  (out_cdone),
        .out_rdone  (out_rdone),
        .out_trunc  (out_trunc),
        .status     (engine_status)
    );

    assign m_tdata = {3'd0, out_value, out_column};
    assign m_tuser = {out_trunc, out_cdone, out_kind};
    assign m_tlast = out_rdone;

    // The column scan only ever runs while a record body is being decoded.
    a_scan_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        engine_status.scan |-> engine_status.phase == rtd_pkg::PH_BODY)
        else $error("column scan active outside the body phase");

    // The last result of a record always closes its column.
    a_rdone_cdone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[3])
        else $error("record done without column done");

    // The queue never holds more words than it has room for.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_status.count <= (rtd_pkg::QPTR_W+1)'(rtd_pkg::QUEUE_DEPTH))
        else $error("input queue overfilled");

    // The engine only takes a word when the result register can accept one.
    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !m_tvalid || m_tready)
        else $error("word taken while a result was stalled");

endmodule

@@ rtl/core/rtd_front.sv @@
// ---------------------------------------------------------------------------
// rtd_front: input side of the decoder
// Takes payload words from the stream and holds them in a short queue so
// that the engine and the upstream source stall independently.
// ---------------------------------------------------------------------------
module rtd_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rtd_pkg::in_word_t       in_word,
    output logic                    q_valid,
    output rtd_pkg::in_word_t       q_word,
    input  logic                    q_pop,
    output rtd_pkg::front_status_t  status
);

    rtd_pkg::in_word_t mem [rtd_pkg::QUEUE_DEPTH];

    logic [rtd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rtd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rtd_pkg::QPTR_W:0]   count_reg, count_next;
    logic                       push;
    logic                       pop;

    assign in_ready = (count_reg != rtd_pkg::QPTR_W'(0) + (rtd_pkg::QPTR_W+1)'(rtd_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_word   = mem[rd_ptr_reg];
    assign status.count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (rtd_pkg::QPTR_W+1)'(push) - (rtd_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_word;
        end
    end

endmodule

@@ rtl/core/rtd_engine.sv @@
// ---------------------------------------------------------------------------
// rtd_engine: record decoding engine
// Walks the header varints into the column table, then decodes the body
// column by column into results held in an output register.
// ---------------------------------------------------------------------------
module rtd_engine
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  rtd_pkg::in_word_t        q_word,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [4:0]               out_column,
    output logic [2:0]               out_kind,
    output logic [63:0]              out_value,
    output logic                     out_cdone,
    output logic                     out_rdone,
    output logic                     out_trunc,
    output rtd_pkg::engine_status_t  status
);

    localparam int unsigned CW = rtd_pkg::COL_W;
    localparam int unsigned NW = rtd_pkg::COUNT_W;

    logic [63:0] type_table [rtd_pkg::CAPACITY];

    rtd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]   bl_reg, bl_next;
    logic [15:0]   hl_reg, hl_next;
    logic [63:0]   va_reg, va_next;
    logic [3:0]    vc_reg, vc_next;
    logic [NW-1:0] ccount_reg, ccount_next;
    logic [NW-1:0] cc_reg, cc_next;
    logic [15:0]   cbl_reg, cbl_next;
    logic [63:0]   vacc_reg, vacc_next;
    logic          ovf_reg, ovf_next;
    logic          scan_reg, scan_next;
    logic          avz_reg, avz_next;

    logic          ov_reg, ov_next;
    logic [4:0]    ocol_reg;
    logic [2:0]    okind_reg;
    logic [63:0]   oval_reg;
    logic          ocd_reg, ord_reg, otr_reg;

    logic            slot;
    logic            emit;
    logic [2:0]      e_kind;
    logic [63:0]     e_val;
    logic            e_cdone;
    logic            e_rdone;
    logic            tbl_we;
    logic [CW-1:0]   tbl_addr;
    logic [63:0]     tbl_data;
    logic            ph_change;
    rtd_pkg::phase_t ph_target;
    rtd_pkg::cls_info_t ti;

    assign slot = !ov_reg || out_ready;
    assign ti   = rtd_pkg::classify(type_table[cc_reg[CW-1:0]]);

    // Datapath and control decisions.
    always_comb
    begin
        rtd_pkg::phase_t ph_e;
        logic [15:0]   bl_e;
        logic [15:0]   bl_n;
        logic [15:0]   hl_n;
        logic [NW-1:0] ccount_e;
        logic          avail0;
        logic          too_long;
        logic          adv;
        logic [63:0]   hl_w;
        logic [63:0]   v;
        rtd_pkg::vint_t vp;

        bl_next     = bl_reg;
        hl_next     = hl_reg;
        va_next     = va_reg;
        vc_next     = vc_reg;
        ccount_next = ccount_reg;
        cc_next     = cc_reg;
        cbl_next    = cbl_reg;
        vacc_next   = vacc_reg;
        ovf_next    = ovf_reg;
        scan_next   = scan_reg;
        avz_next    = avz_reg;
        q_pop       = 1'b0;
        emit        = 1'b0;
        e_kind      = rtd_pkg::KIND_NULL;
        e_val       = '0;
        e_cdone     = 1'b1;
        tbl_we      = 1'b0;
        tbl_addr    = '0;
        tbl_data    = '0;
        ph_change   = 1'b0;
        ph_target   = rtd_pkg::PH_IDLE;
        ph_e        = phase_reg;
        bl_e        = bl_reg;
        bl_n        = bl_reg;
        hl_n        = hl_reg;
        ccount_e    = ccount_reg;
        avail0      = 1'b0;
        too_long    = 1'b0;
        adv         = 1'b0;
        hl_w        = '0;
        v           = '0;
        vp          = '0;

        if (scan_reg)
        begin
            if (slot)
            begin
                if (cc_reg >= ccount_reg)
                begin
                    scan_next = 1'b0;
                    cbl_next  = '0;
                    ph_change = 1'b1;
                    ph_target = rtd_pkg::PH_IDLE;
                end
                else
                begin
                    avail0   = avz_reg || (bl_reg == '0);
                    too_long = ti.big || (ti.len > bl_reg);
                    adv      = 1'b1;
                    if (avail0)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        unique case (ti.cls)
                            rtd_pkg::CL_CONST0, rtd_pkg::CL_CONST1:
                            begin
                                emit   = 1'b1;
                                e_kind = rtd_pkg::KIND_INT;
                                e_val  = {63'd0, ti.cls == rtd_pkg::CL_CONST1};
                            end
                            rtd_pkg::CL_INT, rtd_pkg::CL_FLOAT:
                            begin
                                if (too_long)
                                begin
                                    emit     = 1'b1;
                                    avz_next = 1'b1;
                                end
                                else
                                begin
                                    cbl_next  = ti.len;
                                    vacc_next = '0;
                                    scan_next = 1'b0;
                                    adv       = 1'b0;
                                end
                            end
                            rtd_pkg::CL_BLOB:
                            begin
                                emit   = 1'b1;
                                e_kind = rtd_pkg::KIND_BLOB;
                                if (too_long)
                                begin
                                    avz_next = 1'b1;
                                end
                                else if (ti.len != '0)
                                begin
                                    cbl_next  = ti.len;
                                    scan_next = 1'b0;
                                    adv       = 1'b0;
                                end
                            end
                            rtd_pkg::CL_TEXT:
                            begin
                                if (!ti.big && ti.len == '0)
                                begin
                                    emit   = 1'b1;
                                    e_kind = rtd_pkg::KIND_EMPTY;
                                end
                                else if (too_long)
                                begin
                                    emit     = 1'b1;
                                    avz_next = 1'b1;
                                end
                                else
                                begin
                                    cbl_next  = ti.len;
                                    scan_next = 1'b0;
                                    adv       = 1'b0;
                                end
                            end
                            default:
                            begin
                                emit = 1'b1;
                            end
                        endcase
                    end
                    if (adv)
                    begin
                        cc_next = cc_reg + 1'b1;
                    end
                end
            end
        end
        else if (q_valid && slot)
        begin
            q_pop = 1'b1;
            // A start word resets the record state before the byte is used.
            if (q_word.start)
            begin
                bl_e        = q_word.length;
                ph_e        = (q_word.length == '0) ? rtd_pkg::PH_IDLE : rtd_pkg::PH_HSIZE;
                ccount_e    = '0;
                bl_next     = q_word.length;
                hl_next     = '0;
                va_next     = '0;
                vc_next     = '0;
                ccount_next = '0;
                cc_next     = '0;
                cbl_next    = '0;
                vacc_next   = '0;
                ovf_next    = 1'b0;
                ph_change   = 1'b1;
                ph_target   = ph_e;
            end

            if (ph_e == rtd_pkg::PH_IDLE || bl_e == '0)
            begin
                ph_change = 1'b1;
                ph_target = rtd_pkg::PH_IDLE;
            end
            else
            begin
                bl_n    = bl_e - 16'd1;
                bl_next = bl_n;
                unique case (ph_e)
                    rtd_pkg::PH_HSIZE:
                    begin
                        vp      = rtd_pkg::vint_push(q_word.start ? 64'd0 : va_reg,
                                                     q_word.start ? 4'd0 : vc_reg, q_word.data);
                        va_next = vp.accum;
                        vc_next = vp.count;
                        if (vp.done)
                        begin
                            va_next = '0;
                            vc_next = '0;
                            if (vp.accum <= {60'd0, vp.count} || bl_n == '0)
                            begin
                                ph_change = 1'b1;
                                ph_target = rtd_pkg::PH_IDLE;
                            end
                            else
                            begin
                                hl_w      = vp.accum - {60'd0, vp.count};
                                hl_next   = (|hl_w[63:16]) ? 16'hFFFF : hl_w[15:0];
                                ph_change = 1'b1;
                                ph_target = rtd_pkg::PH_TYPES;
                            end
                        end
                        else if (bl_n == '0)
                        begin
                            ph_change = 1'b1;
                            ph_target = rtd_pkg::PH_IDLE;
                        end
                    end
                    rtd_pkg::PH_TYPES:
                    begin
                        hl_n    = (hl_reg != '0) ? hl_reg - 16'd1 : 16'd0;
                        hl_next = hl_n;
                        vp      = rtd_pkg::vint_push(va_reg, vc_reg, q_word.data);
                        va_next = vp.accum;
                        vc_next = vp.count;
                        if (vp.done)
                        begin
                            if (ccount_reg < NW'(rtd_pkg::CAPACITY))
                            begin
                                tbl_we      = 1'b1;
                                tbl_addr    = ccount_reg[CW-1:0];
                                tbl_data    = vp.accum;
                                ccount_e    = ccount_reg + 1'b1;
                                ccount_next = ccount_e;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            va_next = '0;
                            vc_next = '0;
                        end
                        if (hl_n == '0 || bl_n == '0)
                        begin
                            ph_change = 1'b1;
                            if (ccount_e == '0)
                            begin
                                ph_target = rtd_pkg::PH_IDLE;
                            end
                            else
                            begin
                                va_next   = '0;
                                vc_next   = '0;
                                cc_next   = '0;
                                cbl_next  = '0;
                                vacc_next = '0;
                                ph_target = rtd_pkg::PH_BODY;
                                scan_next = 1'b1;
                                avz_next  = 1'b0;
                            end
                        end
                    end
                    rtd_pkg::PH_BODY:
                    begin
                        if (cbl_reg != '0 && cc_reg < ccount_reg)
                        begin
                            cbl_next = cbl_reg - 16'd1;
                            if (ti.cls == rtd_pkg::CL_TEXT)
                            begin
                                emit    = 1'b1;
                                e_kind  = rtd_pkg::KIND_TEXT;
                                e_val   = {56'd0, q_word.data};
                                e_cdone = (cbl_next == '0);
                            end
                            else if (ti.cls == rtd_pkg::CL_INT || ti.cls == rtd_pkg::CL_FLOAT)
                            begin
                                v         = {vacc_reg[55:0], q_word.data};
                                vacc_next = v;
                                if (cbl_next == '0)
                                begin
                                    emit   = 1'b1;
                                    e_kind = (ti.cls == rtd_pkg::CL_INT) ? rtd_pkg::KIND_INT
                                                                         : rtd_pkg::KIND_FLOAT;
                                    e_val  = v;
                                    if (ti.cls == rtd_pkg::CL_INT)
                                    begin
                                        unique case (ti.len[3:0])
                                            4'd1:    e_val = {{56{v[7]}}, v[7:0]};
                                            4'd2:    e_val = {{48{v[15]}}, v[15:0]};
                                            4'd3:    e_val = {{40{v[23]}}, v[23:0]};
                                            4'd4:    e_val = {{32{v[31]}}, v[31:0]};
                                            4'd6:    e_val = {{16{v[47]}}, v[47:0]};
                                            default: e_val = v;
                                        endcase
                                    end
                                end
                            end
                            if (cbl_next == '0)
                            begin
                                cc_next   = cc_reg + 1'b1;
                                scan_next = 1'b1;
                                avz_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            scan_next = 1'b1;
                            avz_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        ph_change = 1'b1;
                        ph_target = rtd_pkg::PH_IDLE;
                    end
                endcase
            end
        end

        e_rdone = e_cdone && ({1'b0, cc_reg} + 1'b1 == {1'b0, ccount_reg});
    end

    // Next phase.
    always_comb
    begin
        phase_next = ph_change ? ph_target : phase_reg;
    end

    // Output register control.
    always_comb
    begin
        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= rtd_pkg::PH_IDLE;
            bl_reg     <= '0;
            hl_reg     <= '0;
            va_reg     <= '0;
            vc_reg     <= '0;
            ccount_reg <= '0;
            cc_reg     <= '0;
            cbl_reg    <= '0;
            vacc_reg   <= '0;
            ovf_reg    <= 1'b0;
            scan_reg   <= 1'b0;
            avz_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bl_reg     <= bl_next;
            hl_reg     <= hl_next;
            va_reg     <= va_next;
            vc_reg     <= vc_next;
            ccount_reg <= ccount_next;
            cc_reg     <= cc_next;
            cbl_reg    <= cbl_next;
            vacc_reg   <= vacc_next;
            ovf_reg    <= ovf_next;
            scan_reg   <= scan_next;
            avz_reg    <= avz_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            type_table[tbl_addr] <= tbl_data;
        end
        if (emit)
        begin
            ocol_reg  <= cc_reg[CW-1:0];
            okind_reg <= e_kind;
            oval_reg  <= e_val;
            ocd_reg   <= e_cdone;
            ord_reg   <= e_rdone;
            otr_reg   <= ovf_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign out_column   = ocol_reg;
    assign out_kind     = okind_reg;
    assign out_value    = oval_reg;
    assign out_cdone    = ocd_reg;
    assign out_rdone    = ord_reg;
    assign out_trunc    = otr_reg;
    assign status.phase = phase_reg;
    assign status.scan  = scan_reg;

endmodule
